// ----- hdl/sccq_pkg.sv -----
package sccq_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int ANGLE_W = 32;
    localparam int OUT_W   = 18;
    localparam int FOLD_W  = 23;   // folded angle, 0 .. 90 deg in Q16.16
    localparam int RED_W   = 25;   // reduced angle, 0 .. 360 deg

    localparam logic [RED_W-1:0] DEG90  = 25'd5898240;
    localparam logic [RED_W-1:0] DEG180 = 25'd11796480;
    localparam logic [RED_W-1:0] DEG270 = 25'd17694720;
    localparam logic [RED_W-1:0] DEG360 = 25'd23592960;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef struct packed {
        logic [FOLD_W-1:0] f;
        logic              neg;
    } t_fold;

    // Taylor series on magnitudes, Q30 in and out
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t  = ((t * x2) >> 30) / 64'd6;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd42;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd110;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd210;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd272;
        s  = s + t;
        return s;
    endfunction

    function automatic logic [63:0] rom_value(input logic [63:0] x, input int fb);
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] one;
        one = 64'd1 << fb;
        s   = sine_q30(x);
        if (s > ONE_Q30) s = ONE_Q30;
        v = (s + (64'd1 << (29 - fb))) >> (30 - fb);
        if (v > one) v = one;
        return v;
    endfunction

endpackage

// ----- hdl/sccq_reduce.sv -----
module sccq_reduce (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_angle_deg,
    input  logic                 i_mode,
    output logic                 o_valid,
    output sccq_pkg::t_fold      o_fold
);
    import sccq_pkg::*;

    // stage 1: cosine offset, split integer degrees, bias positive
    logic [32:0] a33;
    logic [17:0] xs;
    logic        r_v1;
    logic [16:0] r_x1;
    logic [15:0] r_lo1;

    assign a33 = {i_angle_deg[31], i_angle_deg} + (i_mode ? 33'(DEG90) : 33'd0);
    // 33120 = 92 * 360 keeps the biased degree count positive
    assign xs  = {a33[32], a33[32:16]} + 18'd33120;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_x1  <= xs[16:0];
        r_lo1 <= a33[15:0];
    end

    // stage 2: quotient estimate of x / 360 by reciprocal
    logic [25:0] pq;
    logic        r_v2;
    logic [8:0]  r_q2;
    logic [16:0] r_x2;
    logic [15:0] r_lo2;

    assign pq = 26'(r_x1) * 26'd364;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_q2  <= pq[25:17];
        r_x2  <= r_x1;
        r_lo2 <= r_lo1;
    end

    // stage 3: remainder with one correction, quadrant fold
    logic [16:0]      qm;
    logic [16:0]      rr;
    logic [8:0]       rc;
    logic [RED_W-1:0] d;
    logic [RED_W-1:0] fw;
    logic             n_neg;
    logic             r_v3;
    t_fold            r_fold;

    assign qm = 17'(r_q2) * 17'd360;
    assign rr = r_x2 - qm;
    assign rc = (rr >= 17'd360) ? 9'(rr - 17'd360) : rr[8:0];
    assign d  = {rc, r_lo2};

    always_comb begin
        if (d < DEG90) begin
            fw    = d;
            n_neg = 1'b0;
        end else if (d < DEG180) begin
            fw    = DEG180 - d;
            n_neg = 1'b0;
        end else if (d < DEG270) begin
            fw    = d - DEG180;
            n_neg = 1'b1;
        end else begin
            fw    = DEG360 - d;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_fold.f   <= fw[FOLD_W-1:0];
        r_fold.neg <= n_neg;
    end

    assign o_valid = r_v3;
    assign o_fold  = r_fold;

endmodule

// ----- hdl/sccq_index.sv -----
module sccq_index #(
    parameter int TABLE_ENTRIES = sccq_pkg::TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = sccq_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  sccq_pkg::t_fold                   i_fold,
    output logic                              o_valid,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  o_index,
    output logic [FRAC_BITS-1:0]              o_frac,
    output logic                              o_neg
);
    import sccq_pkg::*;

    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int PW  = FOLD_W + IW;        // f * (entries - 1)
    localparam int NW  = PW - 16;            // integer part of the product
    localparam int UW  = 7 + FRAC_BITS;      // remainder scaled to frac bits
    localparam longint KN = (64'd1 << NW) / 90;
    localparam longint KU = (64'd1 << UW) / 90;

    // stage 4: scale folded angle
    logic          r_v4;
    logic [PW-1:0] r_num4;
    logic          r_neg4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
        end
        r_num4 <= PW'(i_fold.f) * PW'(TABLE_ENTRIES - 1);
        r_neg4 <= i_fold.neg;
    end

    // stage 5: index estimate, n / 90 by reciprocal
    logic [2*NW-1:0] pn;
    logic            r_v5;
    logic [IW-1:0]   r_q5;
    logic [NW-1:0]   r_n5;
    logic [15:0]     r_nlo5;
    logic            r_neg5;

    assign pn = (2*NW)'(r_num4[PW-1:16]) * (2*NW)'(KN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_q5   <= pn[NW+IW-1:NW];
        r_n5   <= r_num4[PW-1:16];
        r_nlo5 <= r_num4[15:0];
        r_neg5 <= r_neg4;
    end

    // stage 6: index correction, remainder scaled to frac bits
    logic [NW-1:0]           qm;
    logic [NW-1:0]           ri;
    logic [6:0]              rc;
    logic [IW-1:0]           n_i;
    logic [23+FRAC_BITS-1:0] vs;
    logic                    r_v6;
    logic [IW-1:0]           r_i6;
    logic [UW-1:0]           r_u6;
    logic                    r_neg6;

    assign qm = NW'(r_q5) * NW'(90);
    assign ri = r_n5 - qm;

    always_comb begin
        if (ri >= NW'(90)) begin
            rc  = 7'(ri - NW'(90));
            n_i = r_q5 + IW'(1);
        end else begin
            rc  = ri[6:0];
            n_i = r_q5;
        end
    end

    assign vs = {rc, r_nlo5, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_i6   <= n_i;
        r_u6   <= vs[23+FRAC_BITS-1:16];
        r_neg6 <= r_neg5;
    end

    // stage 7: fraction estimate, u / 90 by reciprocal
    logic [2*UW-1:0]     pu;
    logic                r_v7;
    logic [FRAC_BITS-1:0] r_fe7;
    logic [UW-1:0]       r_u7;
    logic [IW-1:0]       r_i7;
    logic                r_neg7;

    assign pu = (2*UW)'(r_u6) * (2*UW)'(KU);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= r_v6;
        end
        r_fe7  <= pu[UW+FRAC_BITS-1:UW];
        r_u7   <= r_u6;
        r_i7   <= r_i6;
        r_neg7 <= r_neg6;
    end

    // stage 8: fraction correction
    logic [UW-1:0]        um;
    logic [UW-1:0]        rem;
    logic                 r_v8;
    logic [FRAC_BITS-1:0] r_frac8;
    logic [IW-1:0]        r_i8;
    logic                 r_neg8;

    assign um  = UW'(r_fe7) * UW'(90);
    assign rem = r_u7 - um;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= r_v7;
        end
        r_frac8 <= (rem >= UW'(90)) ? r_fe7 + FRAC_BITS'(1) : r_fe7;
        r_i8    <= r_i7;
        r_neg8  <= r_neg7;
    end

    assign o_valid = r_v8;
    assign o_index = r_i8;
    assign o_frac  = r_frac8;
    assign o_neg   = r_neg8;

endmodule

// ----- hdl/sccq_interp.sv -----
module sccq_interp #(
    parameter int TABLE_ENTRIES = sccq_pkg::TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = sccq_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  i_index,
    input  logic [FRAC_BITS-1:0]              i_frac,
    input  logic                              i_neg,
    output logic                              o_valid,
    output logic [sccq_pkg::OUT_W-1:0]        o_value
);
    import sccq_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int EW = FRAC_BITS + 1;
    localparam int MW = FRAC_BITS + 2;
    localparam int XW = (MW > OUT_W) ? MW : OUT_W;
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
    localparam logic [EW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};

    // quarter-wave table, built at elaboration
    logic [EW-1:0] rom [TABLE_ENTRIES];

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] X = (HALF_PI_Q30 * 64'(k)) / (TABLE_ENTRIES - 1);
        localparam logic [63:0] V = rom_value(X, FRAC_BITS);
        if (k == 0) begin : g_first
            assign rom[k] = '0;
        end else if (k == TABLE_ENTRIES - 1) begin : g_last
            assign rom[k] = ONE;
        end else begin : g_mid
            assign rom[k] = V[EW-1:0];
        end
    end

    // stage 9: table read
    logic [IW-1:0]        ip1;
    logic [EW-1:0]        t_lo;
    logic [EW-1:0]        t_hi;
    logic                 r_v9;
    logic [EW-1:0]        r_lo9;
    logic [EW-1:0]        r_diff9;
    logic [FRAC_BITS-1:0] r_frac9;
    logic                 r_top9;
    logic                 r_neg9;

    assign ip1  = (i_index == LAST) ? i_index : i_index + IW'(1);
    assign t_lo = rom[i_index];
    assign t_hi = rom[ip1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else begin
            r_v9 <= i_valid;
        end
        r_lo9   <= t_lo;
        r_diff9 <= (t_hi >= t_lo) ? t_hi - t_lo : '0;
        r_frac9 <= i_frac;
        r_top9  <= (i_index == LAST);
        r_neg9  <= i_neg;
    end

    // stage 10: interpolate, products truncated
    logic [FRAC_BITS+EW-1:0] prod;
    logic                    r_v10;
    logic [MW-1:0]           r_mag10;
    logic                    r_neg10;

    assign prod = (FRAC_BITS+EW)'(r_frac9) * (FRAC_BITS+EW)'(r_diff9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else begin
            r_v10 <= r_v9;
        end
        r_mag10 <= r_top9 ? MW'(ONE)
                          : MW'(r_lo9) + MW'(prod[FRAC_BITS+EW-1:FRAC_BITS]);
        r_neg10 <= r_neg9;
    end

    // stage 11: apply sign, wrap to the output width
    logic [XW-1:0]    mag_x;
    logic [XW-1:0]    res;
    logic             r_v11;
    logic [OUT_W-1:0] r_value;

    assign mag_x = XW'(r_mag10);
    assign res   = r_neg10 ? XW'(0) - mag_x : mag_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v11 <= 1'b0;
        end else begin
            r_v11 <= r_v10;
        end
        r_value <= res[OUT_W-1:0];
    end

    assign o_valid = r_v11;
    assign o_value = r_value;

endmodule

// ----- hdl/sine_cosine_quarter_table.sv -----
// Sine or cosine of a Q16.16 degree angle from a quarter-wave table with linear
// interpolation. A request is taken on any cycle with start high; busy stays low,
// so one request per clock is sustained. Each result appears on o_value with
// o_valid high for one cycle, in request order; the receiver cannot stall, so
// results must be taken as they come. The pipeline has 3 stages of angle
// reduction and fold, 5 of index and fraction (two reciprocal divides by 90,
// each with a correction stage), and 3 of table read, interpolation and sign.
module sine_cosine_quarter_table #(
    parameter int TABLE_ENTRIES = sccq_pkg::TABLE_ENTRIES_DEF,
    parameter int FRAC_BITS     = sccq_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          i_angle_deg,
    input  logic                        i_mode,
    output logic                        o_valid,
    output logic [sccq_pkg::OUT_W-1:0]  o_value
);
    import sccq_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic                 in_v;
    logic                 fold_v;
    t_fold                fold;
    logic                 idx_v;
    logic [IW-1:0]        idx;
    logic [FRAC_BITS-1:0] frac;
    logic                 neg;

    assign busy = 1'b0;
    assign in_v = start & ~busy;

    sccq_reduce u_reduce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_v),
        .i_angle_deg (i_angle_deg),
        .i_mode      (i_mode),
        .o_valid     (fold_v),
        .o_fold      (fold)
    );

    sccq_index #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fold_v),
        .i_fold  (fold),
        .o_valid (idx_v),
        .o_index (idx),
        .o_frac  (frac),
        .o_neg   (neg)
    );

    sccq_interp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (idx_v),
        .i_index (idx),
        .i_frac  (frac),
        .i_neg   (neg),
        .o_valid (o_valid),
        .o_value (o_value)
    );

    // folded angle never leaves the first quadrant
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fold_v |-> (fold.f <= DEG90[FOLD_W-1:0]))
        else $error("folded angle above 90 degrees");

    // corrected index stays inside the table
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idx_v |-> (idx <= IW'(TABLE_ENTRIES - 1)))
        else $error("table index out of range");

    // a request in the fold stage reaches the index stage, none is lost
    a_index_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fold_v |-> ##5 idx_v)
        else $error("request lost between fold and index");

endmodule
